[hdl/lidar_point_range_image_project_macros.svh]
// Assertion macros for the range-image projection RTL.
`ifndef LIDAR_POINT_RANGE_IMAGE_PROJECT_MACROS_SVH
`define LIDAR_POINT_RANGE_IMAGE_PROJECT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LPRI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LPRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lpri_pkg.sv]
// Shared constants, types and the arctangent table of the range-image projection.
package lpri_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_W     = 63;
  localparam int PRESHIFT_TOP = 60;
  localparam int ANGLE_W      = 32;
  localparam int RING_W       = 6;
  localparam int COL_W        = 12;
  localparam int RANGE_W      = 20;
  localparam int NRINGS_W     = 7;
  localparam int NCOLS_W      = 13;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [NRINGS_W-1:0] NUM_RINGS_RST = 7'd32;
  localparam logic [NCOLS_W-1:0]  COLUMNS_RST   = 13'd1092;
  localparam logic [RANGE_W-1:0]  RANGE_MAX     = '1;
  localparam logic [1:0]          QUAD_HALF     = 2'd2;

  localparam logic [ANGLE_W-1:0] TURN_ATAN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef enum logic {
    REG_NUM_RINGS = 1'b0,
    REG_COLUMNS   = 1'b1
  } lpri_reg_e;

  typedef struct packed {
    logic [1:0]        quad;
    logic              zflag;
    logic [RING_W-1:0] ring;
  } lpri_side_t;

endpackage

[hdl/lpri_prep.sv]
// Front stages: quadrant fold, CORDIC preshift and squared coordinates.
module lpri_prep #(
  parameter int COORD_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [1:0]                           en_i,
  output logic [1:0]                           vld_o,
  input  logic [lpri_pkg::RING_W-1:0]          ring_i,
  input  logic signed [COORD_BITS-1:0]         point_x_i,
  input  logic signed [COORD_BITS-1:0]         point_y_i,
  output lpri_pkg::lpri_side_t                 side_o,
  output logic signed [lpri_pkg::CORDIC_W-1:0] a_o,
  output logic signed [lpri_pkg::CORDIC_W-1:0] b_o,
  output logic [2*COORD_BITS-1:0]              sum_o
);
  import lpri_pkg::*;

  localparam int UW  = COORD_BITS + 1;
  localparam int SW  = 2 * COORD_BITS;
  localparam int PRE = PRESHIFT_TOP - COORD_BITS;

  logic signed [UW-1:0]   u, v, fa, fb;
  logic [1:0]             quad;
  logic [COORD_BITS-1:0]  ax, ay;
  logic [1:0]             vld_q;
  lpri_side_t             side_a_q, side_b_q;
  logic signed [UW-1:0]   fa_q, fb_q;
  logic [SW-1:0]          sqx_q, sqy_q, sum_q;
  logic signed [CORDIC_W-1:0] a_q, b_q;

  always_comb begin
    u  = -UW'(point_x_i);
    v  = -UW'(point_y_i);
    ax = point_x_i[COORD_BITS-1] ? u[COORD_BITS-1:0] : point_x_i;
    ay = point_y_i[COORD_BITS-1] ? v[COORD_BITS-1:0] : point_y_i;
    if (u == '0 && v == '0) begin
      fa   = '0;
      fb   = '0;
      quad = QUAD_HALF;
    end else if (u > 0 && v >= 0) begin
      fa   = u;
      fb   = v;
      quad = 2'd0;
    end else if (u <= 0 && v > 0) begin
      fa   = v;
      fb   = -u;
      quad = 2'd1;
    end else if (u < 0 && v <= 0) begin
      fa   = -u;
      fb   = -v;
      quad = 2'd2;
    end else begin
      fa   = -v;
      fb   = u;
      quad = 2'd3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_i[0]) begin
        vld_q[0] <= in_valid_i;
      end
      if (en_i[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      side_a_q.quad  <= quad;
      side_a_q.zflag <= (fb == '0);
      side_a_q.ring  <= ring_i;
      fa_q           <= fa;
      fb_q           <= fb;
      sqx_q          <= SW'(ax) * SW'(ax);
      sqy_q          <= SW'(ay) * SW'(ay);
    end
    if (en_i[1]) begin
      side_b_q <= side_a_q;
      a_q      <= CORDIC_W'(fa_q) <<< PRE;
      b_q      <= CORDIC_W'(fb_q) <<< PRE;
      sum_q    <= sqx_q + sqy_q;
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_b_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign sum_o  = sum_q;

endmodule

[hdl/lpri_cell.sv]
// One chain cell: a CORDIC vectoring step and a square-root digit step, each passed through beyond its count.
module lpri_cell #(
  parameter int IDX        = 0,
  parameter int COORD_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic                                 en_i,
  output logic                                 valid_o,
  input  lpri_pkg::lpri_side_t                 side_i,
  input  logic signed [lpri_pkg::CORDIC_W-1:0] a_i,
  input  logic signed [lpri_pkg::CORDIC_W-1:0] b_i,
  input  logic signed [lpri_pkg::ANGLE_W-1:0]  z_i,
  input  logic [2*COORD_BITS-1:0]              res_i,
  input  logic [2*COORD_BITS-1:0]              rem_i,
  output lpri_pkg::lpri_side_t                 side_o,
  output logic signed [lpri_pkg::CORDIC_W-1:0] a_o,
  output logic signed [lpri_pkg::CORDIC_W-1:0] b_o,
  output logic signed [lpri_pkg::ANGLE_W-1:0]  z_o,
  output logic [2*COORD_BITS-1:0]              res_o,
  output logic [2*COORD_BITS-1:0]              rem_o
);
  import lpri_pkg::*;

  localparam int SW = 2 * COORD_BITS;

  logic signed [CORDIC_W-1:0] a_d, b_d;
  logic signed [ANGLE_W-1:0]  z_d;
  logic [SW-1:0]              res_d, rem_d;
  logic                       valid_q;
  lpri_side_t                 side_q;
  logic signed [CORDIC_W-1:0] a_q, b_q;
  logic signed [ANGLE_W-1:0]  z_q;
  logic [SW-1:0]              res_q, rem_q;

  if (IDX < CORDIC_STEPS) begin : g_cordic
    logic signed [CORDIC_W-1:0] da, db;
    always_comb begin
      da = b_i >>> IDX;
      db = a_i >>> IDX;
      if (!b_i[CORDIC_W-1]) begin
        a_d = a_i + da;
        b_d = b_i - db;
        z_d = z_i + signed'(TURN_ATAN[IDX]);
      end else begin
        a_d = a_i - da;
        b_d = b_i + db;
        z_d = z_i - signed'(TURN_ATAN[IDX]);
      end
    end
  end else begin : g_cordic_pass
    assign a_d = a_i;
    assign b_d = b_i;
    assign z_d = z_i;
  end

  if (IDX < COORD_BITS) begin : g_sqrt
    localparam int SQ_SHIFT = SW - 2 - 2 * IDX;
    localparam logic [SW:0] SQ_BIT = (SW + 1)'(1) << SQ_SHIFT;
    logic [SW:0] trial;
    always_comb begin
      trial = {1'b0, res_i} + SQ_BIT;
      if ({1'b0, rem_i} >= trial) begin
        rem_d = rem_i - trial[SW-1:0];
        res_d = (res_i >> 1) + SQ_BIT[SW-1:0];
      end else begin
        rem_d = rem_i;
        res_d = res_i >> 1;
      end
    end
  end else begin : g_sqrt_pass
    assign res_d = res_i;
    assign rem_d = rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      a_q    <= a_d;
      b_q    <= b_d;
      z_q    <= z_d;
      res_q  <= res_d;
      rem_q  <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign z_o     = z_q;
  assign res_o   = res_q;
  assign rem_o   = rem_q;

endmodule

[hdl/lpri_post.sv]
// Back stages: angle clamp, column scaling, row mapping and output register.
module lpri_post #(
  parameter int COORD_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [1:0]                          en_i,
  output logic [1:0]                          vld_o,
  input  lpri_pkg::lpri_side_t                side_i,
  input  logic signed [lpri_pkg::ANGLE_W-1:0] z_i,
  input  logic [2*COORD_BITS-1:0]             res_i,
  input  logic [lpri_pkg::NRINGS_W-1:0]       rings_i,
  input  logic [lpri_pkg::NCOLS_W-1:0]        cols_i,
  output logic [lpri_pkg::RING_W-1:0]         pixel_row_o,
  output logic [lpri_pkg::COL_W-1:0]          pixel_col_o,
  output logic [lpri_pkg::RANGE_W-1:0]        range_mm_o,
  output logic                                in_range_o
);
  import lpri_pkg::*;

  localparam int SW = 2 * COORD_BITS;
  localparam int PW = ANGLE_W + NCOLS_W;

  logic [ANGLE_W-3:0]   zc;
  logic [RANGE_W-1:0]   range_sat;
  logic [1:0]           vld_q;
  logic [ANGLE_W-1:0]   angle_q;
  logic [RING_W-1:0]    ring_q;
  logic [RANGE_W-1:0]   range_q;
  logic [PW-1:0]        prod;
  logic                 ok;
  logic [NRINGS_W-1:0]  row_full;
  logic [RING_W-1:0]    pixel_row_q;
  logic [COL_W-1:0]     pixel_col_q;
  logic [RANGE_W-1:0]   range_mm_q;
  logic                 in_range_q;

  always_comb begin
    if (side_i.zflag || z_i[ANGLE_W-1]) begin
      zc = '0;
    end else if (z_i[ANGLE_W-2]) begin
      zc = '1;
    end else begin
      zc = z_i[ANGLE_W-3:0];
    end
    range_sat = (res_i > SW'(RANGE_MAX)) ? RANGE_MAX : res_i[RANGE_W-1:0];
  end

  always_comb begin
    prod     = PW'(angle_q) * PW'(cols_i);
    ok       = ({1'b0, ring_q} < rings_i);
    row_full = rings_i - NRINGS_W'(1) - {1'b0, ring_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_i[0]) begin
        vld_q[0] <= valid_i;
      end
      if (en_i[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      angle_q <= {side_i.quad, zc};
      ring_q  <= side_i.ring;
      range_q <= range_sat;
    end
    if (en_i[1]) begin
      pixel_row_q <= ok ? row_full[RING_W-1:0] : '0;
      pixel_col_q <= prod[ANGLE_W+COL_W-1:ANGLE_W];
      range_mm_q  <= range_q;
      in_range_q  <= ok;
    end
  end

  assign vld_o       = vld_q;
  assign pixel_row_o = pixel_row_q;
  assign pixel_col_o = pixel_col_q;
  assign range_mm_o  = range_mm_q;
  assign in_range_o  = in_range_q;

endmodule

[hdl/lidar_point_range_image_project.sv]
// Top level of the lidar range-image projection: config registers and cell chain.
// Projects one lidar point per cycle onto a range image: row num_rings-1-ring, column from
// the azimuth as a fraction of a turn scaled by the column count, value the floored
// horizontal range in millimetres. A new point is taken every cycle while the output is ready
// or the chain has a gap; each point passes from input transfer to result through the front
// stages, the chain of cells that each run one CORDIC step and one square-root digit, and
// the back stages. A stalled output holds its result while points keep entering until the
// chain has no gaps left. num_rings is clamped to MAX_RINGS and columns_per_ring to
// MAX_COLUMNS; zero columns gives column 0 and zero rings marks every point out of range.
module lidar_point_range_image_project #(
  parameter int COORD_BITS  = 20,
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_RINGS   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpri_pkg::RING_W-1:0]   ring_i,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpri_pkg::RING_W-1:0]   pixel_row_o,
  output logic [lpri_pkg::COL_W-1:0]    pixel_col_o,
  output logic [lpri_pkg::RANGE_W-1:0]  range_mm_o,
  output logic                          in_range_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpri_pkg::APB_AW-1:0]   paddr,
  input  logic [lpri_pkg::APB_DW-1:0]   pwdata,
  output logic [lpri_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import lpri_pkg::*;

`include "lidar_point_range_image_project_macros.svh"

  localparam int SW = 2 * COORD_BITS;
  localparam int N  = (COORD_BITS > CORDIC_STEPS) ? COORD_BITS : CORDIC_STEPS;
  localparam int S  = N + 4;

  logic [NRINGS_W-1:0] num_rings_q;
  logic [NCOLS_W-1:0]  cols_q;
  logic [NRINGS_W-1:0] rings_eff;
  logic [NCOLS_W-1:0]  cols_eff;
  logic                cfg_wr;

  logic [S-1:0] vld;
  logic [S:0]   en;

  lpri_side_t                 side_s [N+1];
  logic signed [CORDIC_W-1:0] a_s    [N+1];
  logic signed [CORDIC_W-1:0] b_s    [N+1];
  logic signed [ANGLE_W-1:0]  z_s    [N+1];
  logic [SW-1:0]              res_s  [N+1];
  logic [SW-1:0]              rem_s  [N+1];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rings_q <= NUM_RINGS_RST;
      cols_q      <= COLUMNS_RST;
    end else if (cfg_wr) begin
      unique case (lpri_reg_e'(paddr[2]))
        REG_NUM_RINGS: num_rings_q <= pwdata[NRINGS_W-1:0];
        REG_COLUMNS:   cols_q      <= pwdata[NCOLS_W-1:0];
        default:       num_rings_q <= num_rings_q;
      endcase
    end
  end

  always_comb begin
    unique case (lpri_reg_e'(paddr[2]))
      REG_NUM_RINGS: prdata = APB_DW'(num_rings_q);
      REG_COLUMNS:   prdata = APB_DW'(cols_q);
      default:       prdata = '0;
    endcase
  end

  assign rings_eff = (32'(num_rings_q) > 32'(MAX_RINGS)) ? NRINGS_W'(MAX_RINGS) : num_rings_q;
  assign cols_eff  = (32'(cols_q) > 32'(MAX_COLUMNS)) ? NCOLS_W'(MAX_COLUMNS) : cols_q;

  // advance a stage when it is empty or the stage after it advances
  assign en[S] = out_ready_i;
  for (genvar i = 0; i < S; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld[S-1];

  lpri_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .en_i       (en[1:0]),
    .vld_o      (vld[1:0]),
    .ring_i     (ring_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .side_o     (side_s[0]),
    .a_o        (a_s[0]),
    .b_o        (b_s[0]),
    .sum_o      (rem_s[0])
  );

  assign z_s[0]   = '0;
  assign res_s[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    lpri_cell #(
      .IDX        (k),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k+1]),
      .en_i    (en[k+2]),
      .valid_o (vld[k+2]),
      .side_i  (side_s[k]),
      .a_i     (a_s[k]),
      .b_i     (b_s[k]),
      .z_i     (z_s[k]),
      .res_i   (res_s[k]),
      .rem_i   (rem_s[k]),
      .side_o  (side_s[k+1]),
      .a_o     (a_s[k+1]),
      .b_o     (b_s[k+1]),
      .z_o     (z_s[k+1]),
      .res_o   (res_s[k+1]),
      .rem_o   (rem_s[k+1])
    );
  end

  lpri_post #(
    .COORD_BITS(COORD_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld[N+1]),
    .en_i        (en[N+3:N+2]),
    .vld_o       (vld[N+3:N+2]),
    .side_i      (side_s[N]),
    .z_i         (z_s[N]),
    .res_i       (res_s[N]),
    .rings_i     (rings_eff),
    .cols_i      (cols_eff),
    .pixel_row_o (pixel_row_o),
    .pixel_col_o (pixel_col_o),
    .range_mm_o  (range_mm_o),
    .in_range_o  (in_range_o)
  );

  `LPRI_ASSERT_IMPL(a_col_below_width, out_valid_o && (cols_eff != '0), ({1'b0, pixel_col_o} < cols_eff), "column not below column count")
  `LPRI_ASSERT_IMPL(a_row_zero_out_of_range, out_valid_o && !in_range_o, (pixel_row_o == '0), "row set on out-of-range point")
  `LPRI_ASSERT_IMPL(a_stall_only_when_full, !in_ready_o, (out_valid_o && !out_ready_i), "input stalled with room in the chain")
  `LPRI_ASSERT_NEXT(a_drain_when_empty, out_valid_o && out_ready_i && !vld[S-2], !out_valid_o, "output valid without a result behind it")

endmodule

[bench/tb.sv]
// Self-checking testbench for the lidar point range-image projection block.
`timescale 1ns / 100ps

module tb;
  import lpri_pkg::*;

  localparam int COORD_BITS  = 20;
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_RINGS   = 64;
  localparam int ATAN_STEPS  = 28;
  localparam int PRESHIFT    = 60 - COORD_BITS;
  localparam longint QUARTER = 64'd1073741824;
  localparam int LATENCY     = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [RING_W-1:0]  row;
    logic [COL_W-1:0]   col;
    logic [RANGE_W-1:0] range_mm;
    logic               in_range;
  } pixel_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [RING_W-1:0]            ring_i;
  logic signed [COORD_BITS-1:0] point_x_i;
  logic signed [COORD_BITS-1:0] point_y_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [RING_W-1:0]            pixel_row_o;
  logic [COL_W-1:0]             pixel_col_o;
  logic [RANGE_W-1:0]           range_mm_o;
  logic                         in_range_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [APB_AW-1:0]            paddr;
  logic [APB_DW-1:0]            pwdata;
  logic [APB_DW-1:0]            prdata;
  logic                         pready;

  logic [NRINGS_W-1:0] cfg_num_rings;
  logic [NCOLS_W-1:0]  cfg_columns;
  pixel_t              expected_pixels [$];
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  hold_off_len;
  int                  hold_requests = 0;
  int                  mismatches = 0;
  int                  readback_errors;
  int                  points_sent;
  int                  results_checked = 0;
  int                  config_writes;
  int                  cycle_count = 0;

  longint atan_turns [0:ATAN_STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5
  };

  lidar_point_range_image_project #(
    .COORD_BITS (COORD_BITS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_RINGS  (MAX_RINGS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ring_i     (ring_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_row_o(pixel_row_o),
    .pixel_col_o(pixel_col_o),
    .range_mm_o (range_mm_o),
    .in_range_o (in_range_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] turn_fraction(longint u, longint v);
    longint a, b, base, z, da, db;
    if (u == 0 && v == 0) return 32'h8000_0000;
    if (u > 0 && v >= 0) begin
      a = u; b = v; base = 0;
    end else if (u <= 0 && v > 0) begin
      a = v; b = -u; base = QUARTER;
    end else if (u < 0 && v <= 0) begin
      a = -u; b = -v; base = 2 * QUARTER;
    end else begin
      a = -v; b = u; base = 3 * QUARTER;
    end
    z = 0;
    if (b != 0) begin
      a = a <<< PRESHIFT;
      b = b <<< PRESHIFT;
      for (int i = 0; i < ATAN_STEPS; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (b >= 0) begin
          a += da; b -= db; z += atan_turns[i];
        end else begin
          a -= da; b += db; z -= atan_turns[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QUARTER - 1) z = QUARTER - 1;
    end
    return 32'(base + z);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned rem, res, bit_w;
    rem = n;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= res + bit_w) begin
        rem -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic pixel_t project_point(logic [RING_W-1:0] ring,
                                           logic signed [COORD_BITS-1:0] x,
                                           logic signed [COORD_BITS-1:0] y);
    pixel_t      p;
    longint      sx, sy, rings, cols, col, rng;
    logic [31:0] angle;
    sx = longint'(x);
    sy = longint'(y);
    rings = (longint'(cfg_num_rings) > longint'(MAX_RINGS)) ? longint'(MAX_RINGS)
                                                            : longint'(cfg_num_rings);
    cols = (longint'(cfg_columns) > longint'(MAX_COLUMNS)) ? longint'(MAX_COLUMNS)
                                                           : longint'(cfg_columns);
    angle = turn_fraction(-sx, -sy);
    col = (longint'(angle) * cols) >>> 32;
    rng = longint'(floor_sqrt(longint'(sx * sx + sy * sy)));
    if (rng > longint'((64'd1 << RANGE_W) - 1)) rng = longint'((64'd1 << RANGE_W) - 1);
    p.in_range = (longint'(ring) < rings);
    p.row = p.in_range ? RING_W'(rings - 1 - longint'(ring)) : '0;
    p.col = COL_W'(col);
    p.range_mm = RANGE_W'(rng);
    return p;
  endfunction

  task automatic note_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches + readback_errors <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic send_point(int ring, int x, int y);
    logic [RING_W-1:0]            r;
    logic signed [COORD_BITS-1:0] px, py;
    pixel_t                       want;
    r = RING_W'(ring);
    px = COORD_BITS'(x);
    py = COORD_BITS'(y);
    want = project_point(r, px, py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ring_i <= r;
    point_x_i <= px;
    point_y_i <= py;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    expected_pixels.insert(expected_pixels.size(), want);
    points_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(lpri_reg_e idx, logic [31:0] value);
    logic [31:0] stored;
    stored = (idx == REG_NUM_RINGS) ? (value & ((32'd1 << NRINGS_W) - 1))
                                    : (value & ((32'd1 << NCOLS_W) - 1));
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NUM_RINGS) cfg_num_rings = value[NRINGS_W-1:0];
    else cfg_columns = value[NCOLS_W-1:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== stored) begin
      readback_errors++;
      if (mismatches + readback_errors <= 10)
        $display("mismatch in register readback: expected %0d, got %0d", stored, prdata);
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    config_writes++;
  endtask

  function automatic int corner_coord(int k);
    case (k)
      0:       return -(1 <<< (COORD_BITS - 1));
      1:       return (1 <<< (COORD_BITS - 1)) - 1;
      2:       return 1;
      3:       return -1;
      default: return 0;
    endcase
  endfunction

  task automatic pick_point(output int ring, output int x, output int y);
    int k;
    ring = int'($urandom_range(63));
    case ($urandom_range(5))
      0, 1: begin
        x = int'($urandom);
        y = int'($urandom);
      end
      2: begin
        k = int'($urandom_range(32));
        x = k - 16;
        k = int'($urandom_range(32));
        y = k - 16;
      end
      3: begin
        x = int'($urandom);
        y = 0;
        if ($urandom_range(1) != 0) begin
          y = x;
          x = 0;
        end
      end
      4: begin
        x = int'($urandom);
        y = ($urandom_range(1) != 0) ? x : -x;
      end
      default: begin
        x = corner_coord(int'($urandom_range(4)));
        y = corner_coord(int'($urandom_range(4)));
      end
    endcase
  endtask

  task automatic send_random_points(int n);
    int ring, x, y;
    for (int i = 0; i < n; i++) begin
      pick_point(ring, x, y);
      send_point(ring, x, y);
    end
  endtask

  task automatic test_reset_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_point(0, 0, 0);
    send_point(1, -1000, 0);
    send_point(31, -524288, 0);
    send_point(32, 524287, 0);
    send_point(63, 0, 524287);
    send_point(5, 0, -524288);
    send_point(10, -524288, -524288);
    send_point(11, 524287, 524287);
    send_point(12, -524288, 524287);
    send_point(13, 524287, -524288);
    send_point(2, 1, 0);
    send_point(3, 0, 1);
    send_point(4, -1, 0);
    send_point(6, 0, -1);
    send_point(7, 1, 1);
    send_point(8, -1, -1);
    send_point(9, 1, -1);
    send_point(14, -1, 1);
    send_point(30, 3000, -4);
    send_point(20, -5, -1);
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    logic [31:0] nr, nc;
    send_idle_pct = 23;
    recv_stall_pct = 23;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0:       begin nr = 1;   nc = 1;    end
        1:       begin nr = 64;  nc = 4096; end
        2:       begin nr = 0;   nc = 0;    end
        3:       begin nr = 127; nc = 8191; end
        4:       begin nr = 65;  nc = 4097; end
        default: begin nr = 17;  nc = 360;  end
      endcase
      write_reg(REG_NUM_RINGS, nr);
      write_reg(REG_COLUMNS, nc);
      send_random_points(40);
      drain_pipeline();
    end
  endtask

  task automatic test_idle_phases();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if ($urandom_range(1) != 0) begin
        write_reg(REG_NUM_RINGS, $urandom_range(1, MAX_RINGS));
        write_reg(REG_COLUMNS, $urandom_range(1, MAX_COLUMNS));
      end else begin
        write_reg(REG_NUM_RINGS, $urandom);
        write_reg(REG_COLUMNS, $urandom);
      end
      send_random_points(160);
      drain_pipeline();
    end
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_NUM_RINGS, 40);
    write_reg(REG_COLUMNS, 2048);
    hold_off_len = 400;
    hold_requests++;
    send_random_points(100);
    drain_pipeline();
  endtask

  initial begin
    int held;
    int holds_served;
    holds_served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_ready_i <= 1'b0;
        held = 0;
        while (held < hold_off_len) begin
          @(posedge clk_i);
          held++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches + readback_errors <= 10) $display("result transfer with nothing pending");
      end else begin
        want = expected_pixels.pop_front();
        results_checked++;
        if (pixel_row_o !== want.row)
          note_mismatch("pixel_row", longint'(want.row), longint'(pixel_row_o));
        if (pixel_col_o !== want.col)
          note_mismatch("pixel_col", longint'(want.col), longint'(pixel_col_o));
        if (range_mm_o !== want.range_mm)
          note_mismatch("range_mm", longint'(want.range_mm), longint'(range_mm_o));
        if (in_range_o !== want.in_range)
          note_mismatch("in_range", longint'(want.in_range), longint'(in_range_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    ring_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_len = 0;
    readback_errors = 0;
    points_sent = 0;
    config_writes = 0;
    cfg_num_rings = NUM_RINGS_RST;
    cfg_columns = COLUMNS_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_directed();
    test_register_extremes();
    test_idle_phases();
    test_output_hold_off();
    drain_pipeline();
    $display("projected %0d points over %0d register writes, %0d results checked",
             points_sent, config_writes, results_checked);
    $display("covered reset values, register extremes, four idle mixes and a long output stall");
    if (mismatches == 0 && readback_errors == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
